/* src/tsfc_pkg.sv */
// Shared types, codes and the CRC-8 step for the temperature sensor frame checker.
package tsfc_pkg;

    localparam int POS_W   = 4;
    localparam int TEMP_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int ROM_BYTES_DEFAULT     = 8;
    localparam int SCRATCH_BYTES_DEFAULT = 9;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

    typedef enum logic [1:0] {
        REQ_ROM     = 2'd0,
        REQ_CONVERT = 2'd1,
        REQ_SCRATCH = 2'd2,
        REQ_READ    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        LS_NOT_READY  = 2'd0,
        LS_IDLE       = 2'd1,
        LS_CONVERTING = 2'd2,
        LS_READY      = 2'd3
    } life_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_TIMING = 2'd1,
        ERR_CRC    = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        ST_MID  = 2'd0,
        ST_OK   = 2'd1,
        ST_FAIL = 2'd2
    } status_t;

    typedef struct packed {
        req_t              req_type;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        err_t                     error_code;
        life_t                    sensor_state;
        logic signed [TEMP_W-1:0] temperature;
        status_t                  status;
    } result_t;

    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data_in);
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] d;
        logic              mix;
        crc = crc_in;
        d   = data_in;
        for (int i = 0; i < BYTE_W; i++) begin
            mix = crc[0] ^ d[0];
            crc = crc >> 1;
            if (mix) begin
                crc = crc ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

endpackage

/* src/tsfc_core.sv */
// Sensor state, frame tracking and CRC check; computes one result per request.
module tsfc_core #(
    parameter int ROM_BYTES     = tsfc_pkg::ROM_BYTES_DEFAULT,
    parameter int SCRATCH_BYTES = tsfc_pkg::SCRATCH_BYTES_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  tsfc_pkg::item_t   item,
    output tsfc_pkg::result_t result
);
    import tsfc_pkg::*;

    localparam logic [POS_W-1:0] ROM_LAST = POS_W'(ROM_BYTES - 1);
    localparam logic [POS_W-1:0] SP_LAST  = POS_W'(SCRATCH_BYTES - 1);

    life_t                    life_reg, life_next;
    err_t                     err_reg, err_next;
    logic signed [TEMP_W-1:0] held_reg, held_next;
    logic [BYTE_W-1:0]        crc_reg, crc_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [BYTE_W-1:0]        cap_reg, cap_next;
    logic                     ign_reg, ign_next;
    logic                     sp_reg, sp_next;

    logic                     is_sp;
    logic [POS_W-1:0]         last_pos;
    logic [POS_W-1:0]         pos_cur;
    logic [BYTE_W-1:0]        crc_cur;
    logic                     ign_cur;
    status_t                  status;
    logic signed [TEMP_W-1:0] temp_out;

    always_comb begin
        life_next = life_reg;
        err_next  = err_reg;
        held_next = held_reg;
        crc_next  = crc_reg;
        pos_next  = pos_reg;
        cap_next  = cap_reg;
        ign_next  = ign_reg;
        sp_next   = sp_reg;
        status    = ST_MID;
        temp_out  = '0;
        is_sp     = (item.req_type == REQ_SCRATCH);
        last_pos  = is_sp ? SP_LAST : ROM_LAST;
        pos_cur   = pos_reg;
        crc_cur   = crc_reg;
        ign_cur   = ign_reg;
        unique case (item.req_type)
            REQ_ROM, REQ_SCRATCH: begin
                if (pos_cur != '0 && sp_reg != is_sp) begin
                    pos_cur = '0;
                end
                if (pos_cur == '0) begin
                    sp_next = is_sp;
                    crc_cur = '0;
                    ign_cur = is_sp && (life_reg != LS_CONVERTING);
                end
                ign_next = ign_cur;
                if (pos_cur == last_pos) begin
                    pos_next = '0;
                    crc_next = crc_cur;
                    if (is_sp) begin
                        if (ign_cur) begin
                            err_next = ERR_TIMING;
                            status   = ST_FAIL;
                        end else if (item.data_byte == crc_cur) begin
                            life_next = LS_READY;
                            status    = ST_OK;
                        end else begin
                            err_next = ERR_CRC;
                            status   = ST_FAIL;
                        end
                    end else begin
                        if (item.data_byte == crc_cur) begin
                            life_next = LS_IDLE;
                            status    = ST_OK;
                        end else begin
                            status = ST_FAIL;
                        end
                    end
                end else begin
                    crc_next = crc8_step(crc_cur, item.data_byte);
                    if (is_sp && !ign_cur) begin
                        if (pos_cur == POS_W'(0)) begin
                            cap_next = item.data_byte;
                        end else if (pos_cur == POS_W'(1)) begin
                            held_next = {item.data_byte[TEMP_W-BYTE_W-1:0], cap_reg};
                        end
                    end
                    pos_next = pos_cur + POS_W'(1);
                end
            end
            REQ_CONVERT: begin
                pos_next = '0;
                if (life_reg == LS_IDLE || life_reg == LS_READY) begin
                    life_next = LS_CONVERTING;
                    status    = ST_OK;
                end else begin
                    err_next = ERR_TIMING;
                    status   = ST_FAIL;
                end
            end
            REQ_READ: begin
                pos_next = '0;
                if (life_reg == LS_READY && err_reg == ERR_NONE) begin
                    temp_out  = held_reg;
                    held_next = '0;
                    life_next = LS_IDLE;
                    status    = ST_OK;
                end else begin
                    err_next = ERR_NONE;
                    status   = ST_FAIL;
                end
            end
            default: begin
                status = ST_FAIL;
            end
        endcase
    end

    always_comb begin
        result.status       = status;
        result.temperature  = temp_out;
        result.sensor_state = life_next;
        result.error_code   = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            life_reg <= LS_NOT_READY;
            err_reg  <= ERR_NONE;
            held_reg <= '0;
            crc_reg  <= '0;
            pos_reg  <= '0;
            ign_reg  <= 1'b0;
            sp_reg   <= 1'b0;
        end else if (step_en) begin
            life_reg <= life_next;
            err_reg  <= err_next;
            held_reg <= held_next;
            crc_reg  <= crc_next;
            pos_reg  <= pos_next;
            ign_reg  <= ign_next;
            sp_reg   <= sp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            cap_reg <= cap_next;
        end
    end

endmodule

/* src/temp_sensor_frame_checker_unit.sv */
// Top level: request input register, checker core and result register.
// Host-side checker for a one-wire temperature sensor. Each request (ROM byte,
// convert, scratchpad byte or read) yields exactly one result carrying status,
// read temperature, sensor state and error code. A request can be taken every
// cycle unless backpressure on the master side has filled both registers. Each
// request is held in the input register, then makes one pass through the core
// (an unrolled eight-bit CRC-8 step) into the result register, from which it is
// presented on the master side. Both registers hold under backpressure, and a
// new request is still taken while a finished result waits on the master side.
module temp_sensor_frame_checker_unit #(
    parameter int ROM_BYTES     = tsfc_pkg::ROM_BYTES_DEFAULT,
    parameter int SCRATCH_BYTES = tsfc_pkg::SCRATCH_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [1:0] status, [13:2] temperature,
                                   // [15:14] sensor_state, [17:16] error_code, zero pad
);
    import tsfc_pkg::*;

    logic    in_vld_reg;
    item_t   in_item_reg;
    logic    out_vld_reg;
    result_t out_res_reg;
    result_t core_res;
    logic    advance;
    logic    s_fire;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.req_type  <= req_t'(s_tuser);
            in_item_reg.data_byte <= s_tdata;
        end
    end

    tsfc_core #(
        .ROM_BYTES     (ROM_BYTES),
        .SCRATCH_BYTES (SCRATCH_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_res_reg.error_code, out_res_reg.sensor_state,
                       out_res_reg.temperature, out_res_reg.status};

endmodule
